@@ src/edge_triggered_sample_capture_macros.svh @@
// ----------------------------------------------------------------------------
// Edge-triggered sample capture: assertion macros
// Shorthand for the concurrent checks kept at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EDGE_TRIGGERED_SAMPLE_CAPTURE_MACROS_SVH
`define EDGE_TRIGGERED_SAMPLE_CAPTURE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ETSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etsc: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ETSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etsc: next-cycle check failed");

`endif

@@ src/etsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Edge-triggered sample capture: shared package
// Field widths, register and command codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package etsc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RIDX_W     = 10;
    localparam int OFFSET_W   = 10;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int RING_DEPTH_DEF = 1024;

    // Samples above this level are dropped.
    localparam logic [SAMPLE_W-1:0] MAX_SAMPLE = 16'd4095;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_EN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LEVEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_OFFSET = 2'd3;

    // Trigger modes; the other codes never trigger.
    localparam logic [MODE_W-1:0] MODE_RISING  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FALLING = 2'd1;

    // Input commands.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_RDATA,
        ST_SETUP,
        ST_COPY
    } t_state;

    typedef struct packed {
        logic clear_we;
        logic sample_go;
        logic fire_latch;
        logic read_latch;
        logic reduce_sub;
        logic read_load;
        logic copy_setup;
        logic copy_step;
        logic fire_finish;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic will_fire;
        logic clr_last;
        logic ridx_big;
        logic copy_done;
    } t_status;

endpackage

@@ src/etsc_ram.sv @@
// ----------------------------------------------------------------------------
// Edge-triggered sample capture: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module etsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/etsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Edge-triggered sample capture: controller
// Sequences the clearing pass, sample beats, read commands and the
// pre-trigger copy, and owns the handshake on both channels.
// ----------------------------------------------------------------------------
module etsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  etsc_pkg::t_status i_sts,
    output etsc_pkg::t_cmd    o_ctl
);

    import etsc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_in_ready;
    logic   w_load;
    t_cmd   w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // The output register is free if it is empty or being emptied this cycle.
    assign w_in_ready = (r_state == ST_IDLE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        w_ctl   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_ctl.clear_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid && w_in_ready) begin
                    if (i_sts.is_read) begin
                        w_ctl.read_latch = 1'b1;
                        n_state          = ST_REDUCE;
                    end else if (i_sts.will_fire) begin
                        w_ctl.fire_latch = 1'b1;
                        n_state          = ST_SETUP;
                    end else begin
                        w_ctl.sample_go = 1'b1;
                    end
                end
            end
            ST_REDUCE: begin
                if (i_sts.ridx_big) begin
                    w_ctl.reduce_sub = 1'b1;
                end else begin
                    n_state = ST_RDATA;
                end
            end
            ST_RDATA: begin
                w_ctl.read_load = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_SETUP: begin
                w_ctl.copy_setup = 1'b1;
                n_state          = ST_COPY;
            end
            ST_COPY: begin
                if (i_sts.copy_done) begin
                    w_ctl.fire_finish = 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    w_ctl.copy_step = 1'b1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign w_load = w_ctl.sample_go || w_ctl.read_load || w_ctl.fire_finish;

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = !w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_ctl       = w_ctl;

endmodule

@@ src/etsc_dp.sv @@
// ----------------------------------------------------------------------------
// Edge-triggered sample capture: datapath
// Configuration registers, ring pointers, trigger detection, the two
// sample memories and the result register.
// ----------------------------------------------------------------------------
module etsc_dp #(
    parameter int RING_DEPTH = etsc_pkg::RING_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [etsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [etsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_cmd,
    input  logic [etsc_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [etsc_pkg::RIDX_W-1:0]     i_read_index,
    input  etsc_pkg::t_cmd                  i_ctl,
    output etsc_pkg::t_status               o_sts,
    output logic                            o_sample_accepted,
    output logic                            o_capturing,
    output logic                            o_capture_done,
    output logic [etsc_pkg::SAMPLE_W-1:0]   o_read_data
);

    import etsc_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int RW = (AW > RIDX_W) ? AW : RIDX_W;
    localparam int CW = (RW > AW) ? RW : AW + 1;
    localparam int SW = ((AW > OFFSET_W) ? AW : OFFSET_W) + 2;

    localparam logic [AW:0]            DEPTH_A = (AW + 1)'(RING_DEPTH);
    localparam logic [CW-1:0]          DEPTH_C = CW'(RING_DEPTH);
    localparam logic [AW-1:0]          LAST_A  = AW'(RING_DEPTH - 1);
    localparam logic signed [SW-1:0]   HALF_S  = SW'(RING_DEPTH / 2);
    localparam logic signed [SW-1:0]   LAST_S  = SW'(RING_DEPTH - 1);

    // Configuration.
    logic                       r_trig_en;
    logic [MODE_W-1:0]          r_mode;
    logic [SAMPLE_W-1:0]        r_level;
    logic [OFFSET_W-1:0]        r_off;

    // Ring state.
    logic [AW-1:0]              r_hp;
    logic [AW-1:0]              r_cp;
    logic                       r_trig;
    logic [SAMPLE_W-1:0]        r_prev;
    logic [AW-1:0]              r_clr_cnt;

    // Work registers.
    logic [SAMPLE_W-1:0]        r_s;
    logic [AW-1:0]              r_cnt;
    logic [RW-1:0]              r_ridx;
    logic [RW-1:0]              n_ridx;
    logic [AW-1:0]              r_rd_addr;
    logic [AW-1:0]              r_issue;
    logic [AW-1:0]              r_wr_idx;
    logic                       r_pend;

    // Result register.
    logic                       r_acc;
    logic                       r_capt;
    logic                       r_done;
    logic [SAMPLE_W-1:0]        r_rdata;

    logic                       w_ok;
    logic                       w_rise;
    logic                       w_fall;
    logic                       w_fire;
    logic                       w_cp_nz;
    logic                       w_put;
    logic                       w_done;
    logic                       w_trig_n;
    logic signed [SW-1:0]       w_sum;
    logic [AW-1:0]              w_pre;
    logic [AW:0]                w_base_raw;
    logic [AW:0]                w_base_wrap;
    logic [CW-1:0]              w_ridx_x;
    logic                       w_ridx_big;
    logic                       w_issue_more;

    logic                       w_h_we;
    logic [AW-1:0]              w_h_waddr;
    logic [SAMPLE_W-1:0]        w_h_wdata;
    logic [SAMPLE_W-1:0]        w_h_rdata;
    logic                       w_c_we;
    logic [AW-1:0]              w_c_waddr;
    logic [SAMPLE_W-1:0]        w_c_wdata;
    logic [SAMPLE_W-1:0]        w_c_rdata;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        logic [AW:0] s;
        s = {1'b0, a} + (AW + 1)'(1);
        return (s == DEPTH_A) ? '0 : s[AW-1:0];
    endfunction

    // Trigger detection against the last sample written to the history ring.
    assign w_ok    = (i_sample <= MAX_SAMPLE);
    assign w_rise  = (r_mode == MODE_RISING)  && (r_prev < r_level) && (i_sample > r_level);
    assign w_fall  = (r_mode == MODE_FALLING) && (r_prev > r_level) && (i_sample < r_level);
    assign w_fire  = w_ok && r_trig_en && !r_trig && (w_rise || w_fall);
    assign w_cp_nz = (r_cp != '0);
    assign w_put   = w_ok && (!r_trig_en || (r_trig && w_cp_nz));
    assign w_done  = w_ok && r_trig_en && r_trig && !w_cp_nz;
    assign w_trig_n = w_ok ? (r_trig_en && r_trig && w_cp_nz) : r_trig;

    // Pre-trigger count, clamped between zero and one less than the depth of the ring.
    assign w_sum = HALF_S + signed'({{(SW - OFFSET_W){r_off[OFFSET_W-1]}}, r_off});
    always_comb begin
        if (w_sum < 0) begin
            w_pre = '0;
        end else if (w_sum > LAST_S) begin
            w_pre = LAST_A;
        end else begin
            w_pre = w_sum[AW-1:0];
        end
    end

    // Oldest history entry that goes into the capture store.
    assign w_base_raw  = {1'b0, r_hp} + DEPTH_A - {1'b0, r_cnt};
    assign w_base_wrap = (w_base_raw >= DEPTH_A) ? (w_base_raw - DEPTH_A) : w_base_raw;

    // The read index is brought below the depth one subtraction a cycle.
    assign w_ridx_x   = CW'(r_ridx);
    assign w_ridx_big = (w_ridx_x >= DEPTH_C);
    assign n_ridx     = RW'(w_ridx_x - DEPTH_C);

    assign w_issue_more = (r_issue != r_cnt);

    always_comb begin
        w_h_we    = 1'b0;
        w_h_waddr = r_hp;
        w_h_wdata = i_sample;
        w_c_we    = 1'b0;
        w_c_waddr = r_cp;
        w_c_wdata = i_sample;
        if (i_ctl.clear_we) begin
            w_h_we    = 1'b1;
            w_h_waddr = r_clr_cnt;
            w_h_wdata = '0;
            w_c_we    = 1'b1;
            w_c_waddr = r_clr_cnt;
            w_c_wdata = '0;
        end else if (i_ctl.sample_go) begin
            w_h_we = w_ok;
            w_c_we = w_put;
        end else if (i_ctl.copy_step) begin
            w_c_we    = r_pend;
            w_c_waddr = r_wr_idx;
            w_c_wdata = w_h_rdata;
        end else if (i_ctl.fire_finish) begin
            w_h_we    = 1'b1;
            w_h_wdata = r_s;
            w_c_we    = 1'b1;
            w_c_waddr = r_cnt;
            w_c_wdata = r_s;
        end
    end

    etsc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_h_we),
        .i_waddr (w_h_waddr),
        .i_wdata (w_h_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (w_h_rdata)
    );

    etsc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_raddr (r_ridx[AW-1:0]),
        .o_rdata (w_c_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_en <= 1'b0;
            r_mode    <= '0;
            r_level   <= '0;
            r_off     <= '0;
            r_hp      <= '0;
            r_cp      <= '0;
            r_trig    <= 1'b0;
            r_prev    <= '0;
            r_clr_cnt <= '0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TRIG_EN:    r_trig_en <= i_cfg_data[0];
                    CFG_TRIG_MODE:  r_mode    <= i_cfg_data[MODE_W-1:0];
                    CFG_TRIG_LEVEL: r_level   <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_PRE_OFFSET: r_off     <= i_cfg_data[OFFSET_W-1:0];
                endcase
            end
            if (i_ctl.clear_we) begin
                r_clr_cnt <= f_inc(r_clr_cnt);
            end
            if (i_ctl.sample_go && w_ok) begin
                r_hp   <= f_inc(r_hp);
                r_prev <= i_sample;
                r_trig <= w_trig_n;
                if (w_put) begin
                    r_cp <= f_inc(r_cp);
                end
            end
            if (i_ctl.copy_setup) begin
                r_pend <= 1'b0;
            end
            if (i_ctl.copy_step) begin
                r_pend <= w_issue_more;
            end
            if (i_ctl.fire_finish) begin
                r_hp   <= f_inc(r_hp);
                r_prev <= r_s;
                r_trig <= 1'b1;
                r_cp   <= f_inc(r_cnt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire_latch) begin
            r_s   <= i_sample;
            r_cnt <= w_pre;
        end
        if (i_ctl.read_latch) begin
            r_ridx <= RW'(i_read_index);
        end
        if (i_ctl.reduce_sub) begin
            r_ridx <= n_ridx;
        end
        if (i_ctl.copy_setup) begin
            r_rd_addr <= w_base_wrap[AW-1:0];
            r_issue   <= '0;
        end
        // Reads run ahead of the matching capture write, through the registered history read data.
        if (i_ctl.copy_step && w_issue_more) begin
            r_rd_addr <= f_inc(r_rd_addr);
            r_issue   <= r_issue + AW'(1);
            r_wr_idx  <= r_issue;
        end
        if (i_ctl.sample_go) begin
            r_acc   <= w_ok;
            r_capt  <= w_trig_n;
            r_done  <= w_done;
            r_rdata <= '0;
        end else if (i_ctl.read_load) begin
            r_acc   <= 1'b0;
            r_capt  <= r_trig;
            r_done  <= 1'b0;
            r_rdata <= w_c_rdata;
        end else if (i_ctl.fire_finish) begin
            r_acc   <= 1'b1;
            r_capt  <= 1'b1;
            r_done  <= 1'b0;
            r_rdata <= '0;
        end
    end

    assign o_sts.is_read   = (i_cmd == CMD_READ);
    assign o_sts.will_fire = w_fire;
    assign o_sts.clr_last  = (r_clr_cnt == LAST_A);
    assign o_sts.ridx_big  = w_ridx_big;
    assign o_sts.copy_done = !w_issue_more && !r_pend;

    assign o_sample_accepted = r_acc;
    assign o_capturing       = r_capt;
    assign o_capture_done    = r_done;
    assign o_read_data       = r_rdata;

endmodule

@@ src/edge_triggered_sample_capture.sv @@
// ----------------------------------------------------------------------------
// Edge-triggered sample capture: top level
// One scope channel with a history ring, edge trigger, pre-trigger copy
// and a capture store that is read back by command.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_cmd, i_sample, i_read_index
//   out      source     o_out_valid / i_out_stall  o_sample_accepted, o_capturing,
//                                                  o_capture_done, o_read_data
//   cfg      sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// A sample beat that does not fire the trigger keeps the controller in ST_IDLE,
// so samples stream at one beat a cycle while the result register drains.
// A firing sample passes through ST_SETUP and ST_COPY, where the pre-trigger
// entries are copied from history to capture RAM at one entry a cycle.
// A read passes through ST_REDUCE, where the index is reduced by one
// subtraction a cycle, and ST_RDATA, which loads the registered capture RAM read.
// After reset every entry of both RAMs is cleared with o_in_stall high.
// A stalled result holds the next beat back only until it is taken.
// ----------------------------------------------------------------------------
`include "edge_triggered_sample_capture_macros.svh"

module edge_triggered_sample_capture #(
    parameter int RING_DEPTH = etsc_pkg::RING_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [etsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [etsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic [etsc_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [etsc_pkg::RIDX_W-1:0]     i_read_index,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_sample_accepted,
    output logic                            o_capturing,
    output logic                            o_capture_done,
    output logic [etsc_pkg::SAMPLE_W-1:0]   o_read_data
);

    import etsc_pkg::*;

    t_cmd    w_ctl;
    t_status w_sts;

    etsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    etsc_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (i_cmd),
        .i_sample          (i_sample),
        .i_read_index      (i_read_index),
        .i_ctl             (w_ctl),
        .o_sts             (w_sts),
        .o_sample_accepted (o_sample_accepted),
        .o_capturing       (o_capturing),
        .o_capture_done    (o_capture_done),
        .o_read_data       (o_read_data)
    );

    // A waiting result beat that is stalled must hold back new input beats.
    `ETSC_ASSERT_IMPL(a_blocked_output_stalls_input, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)
    // No input beat is taken while the memories are being cleared.
    `ETSC_ASSERT_IMPL(a_clear_stalls_input, i_clk, i_rst_n, w_ctl.clear_we, o_in_stall)
    // The rearm beat is a stored sample that leaves capturing low.
    `ETSC_ASSERT_IMPL(a_rearm_beat_fields, i_clk, i_rst_n, o_out_valid && o_capture_done, !o_capturing && o_sample_accepted)
    // The end of a pre-trigger copy presents a capturing result.
    `ETSC_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_ctl.fire_finish, o_out_valid && o_capturing)

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Edge-triggered sample capture: testbench
// Drives sample and read beats through the valid/stall input channel and
// compares every result beat with an in-bench model of the history ring,
// edge trigger, pre-trigger copy and capture store, or with the fixed
// expectation of a directed row. A directed plan covers the extremes and
// the special cases, then random phases under randomly chosen trigger
// settings follow, with random idling on both channels.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import etsc_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;
    localparam int RANDOM_BEATS = 1800;
    localparam int CALM_BEATS = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT = 700;

    localparam logic [MODE_W-1:0] MODE_NEVER = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic                accepted;
        logic                capturing;
        logic                done;
        logic [SAMPLE_W-1:0] rdata;
    } t_capture_res;

    typedef enum logic {
        ROW_CFG,
        ROW_BEAT
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  cmd;
        logic [SAMPLE_W-1:0]   smp;
        logic [RIDX_W-1:0]     ridx;
        logic                  typed;
        t_capture_res          want;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_cmd;
    logic [SAMPLE_W-1:0]   i_sample;
    logic [RIDX_W-1:0]     i_read_index;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_sample_accepted;
    logic                  o_capturing;
    logic                  o_capture_done;
    logic [SAMPLE_W-1:0]   o_read_data;

    // Model of the channel.
    logic [SAMPLE_W-1:0] hist_mem [DEPTH];
    logic [SAMPLE_W-1:0] cap_mem [DEPTH];
    logic [RIDX_W-1:0]   hist_wp;
    logic [RIDX_W-1:0]   cap_wp;
    logic                triggered;
    logic                cfg_trig_en;
    logic [MODE_W-1:0]   cfg_mode;
    logic [SAMPLE_W-1:0] cfg_level;
    logic signed [OFFSET_W-1:0] cfg_offset;

    t_capture_res pending_results[$];
    t_plan_row    plan[$];
    t_capture_res beat_want;
    logic         beat_typed;
    int           results_seen;
    int           fail_count;
    bit           calm;

    int hold_left;
    int burst_left;
    bit held_off;

    edge_triggered_sample_capture u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_sample          (i_sample),
        .i_read_index      (i_read_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sample_accepted (o_sample_accepted),
        .o_capturing       (o_capturing),
        .o_capture_done    (o_capture_done),
        .o_read_data       (o_read_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("edge_triggered_sample_capture verification failed");
        $finish;
    end

    task automatic note_failure(input string msg);
        $display("%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic void store_capture(input logic [SAMPLE_W-1:0] smp);
        cap_mem[cap_wp] = smp;
        cap_wp++;
    endfunction

    function automatic t_capture_res predict_capture(input logic cmd,
                                                     input logic [SAMPLE_W-1:0] smp,
                                                     input logic [RIDX_W-1:0] ridx);
        t_capture_res r;
        logic [SAMPLE_W-1:0] prev;
        logic hit;
        int n;
        logic [RIDX_W-1:0] src;
        r = '0;
        if (cmd == CMD_READ) begin
            r.rdata = cap_mem[ridx];
        end else if (smp <= MAX_SAMPLE) begin
            r.accepted = 1'b1;
            if (!cfg_trig_en) begin
                triggered = 1'b0;
                store_capture(smp);
            end else if (!triggered) begin
                // The crossing is judged against the last sample in the history ring.
                prev = hist_mem[hist_wp - 10'd1];
                hit = (cfg_mode == MODE_RISING && prev < cfg_level && smp > cfg_level) ||
                      (cfg_mode == MODE_FALLING && prev > cfg_level && smp < cfg_level);
                if (hit) begin
                    triggered = 1'b1;
                    n = DEPTH / 2 + int'(cfg_offset);
                    if (n < 0) n = 0;
                    if (n > DEPTH - 1) n = DEPTH - 1;
                    src = hist_wp - RIDX_W'(n);
                    for (int i = 0; i < n; i++) begin
                        cap_mem[i] = hist_mem[src];
                        src++;
                    end
                    cap_wp = RIDX_W'(n);
                    store_capture(smp);
                end
            end else if (cap_wp != '0) begin
                store_capture(smp);
            end else begin
                // The store has wrapped: this sample rearms and goes only into the history ring.
                triggered = 1'b0;
                r.done = 1'b1;
            end
            hist_mem[hist_wp] = smp;
            hist_wp++;
        end
        r.capturing = triggered;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_capture_res got;
        t_capture_res want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_sample_accepted, o_capturing, o_capture_done, o_read_data};
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("result beat %0d arrived with nothing pending",
                                           results_seen));
                end else begin
                    want = pending_results.pop_front();
                    if (got.accepted !== want.accepted)
                        note_failure($sformatf("beat %0d sample_accepted %0b, expected %0b",
                                               results_seen, got.accepted, want.accepted));
                    if (got.capturing !== want.capturing)
                        note_failure($sformatf("beat %0d capturing %0b, expected %0b",
                                               results_seen, got.capturing, want.capturing));
                    if (got.done !== want.done)
                        note_failure($sformatf("beat %0d capture_done %0b, expected %0b",
                                               results_seen, got.done, want.done));
                    if (got.rdata !== want.rdata)
                        note_failure($sformatf("beat %0d read_data %0h, expected %0h",
                                               results_seen, got.rdata, want.rdata));
                end
                results_seen++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TRIG_EN:    cfg_trig_en = i_cfg_data[0];
                    CFG_TRIG_MODE:  cfg_mode = i_cfg_data[MODE_W-1:0];
                    CFG_TRIG_LEVEL: cfg_level = i_cfg_data[SAMPLE_W-1:0];
                    CFG_PRE_OFFSET: cfg_offset = i_cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                want = predict_capture(i_cmd, i_sample, i_read_index);
                if (beat_typed) want = beat_want;
                pending_results.push_back(want);
            end
        end
    end

    // Result side: random stall bursts, and one long hold-off that backs the
    // block up until it stalls its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else if (!held_off && results_seen >= HOLD_AT) begin
            held_off = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall = 1'b1;
        end else if (calm) begin
            i_out_stall = 1'b0;
        end else if (burst_left > 0) begin
            burst_left--;
            i_out_stall = 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(0, 11);
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_beat(input logic cmd, input logic [SAMPLE_W-1:0] smp,
                             input logic [RIDX_W-1:0] ridx, input logic typed,
                             input t_capture_res want);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd = cmd;
        i_sample = smp;
        i_read_index = ridx;
        beat_typed = typed;
        beat_want = want;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and let every outstanding result drain before the block is
    // reconfigured; a firing sample may still be copying history.
    task automatic settle();
        int waited;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        t_plan_row row;
        row = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, cmd: 1'b0, smp: '0, ridx: '0,
                typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void plan_beat(input logic cmd, input logic [SAMPLE_W-1:0] smp,
                                      input logic [RIDX_W-1:0] ridx);
        t_plan_row row;
        row = '{kind: ROW_BEAT, reg_idx: '0, reg_val: '0, cmd: cmd, smp: smp, ridx: ridx,
                typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void plan_fixed(input logic cmd, input logic [SAMPLE_W-1:0] smp,
                                       input logic [RIDX_W-1:0] ridx, input logic acc,
                                       input logic cap, input logic done,
                                       input logic [SAMPLE_W-1:0] rdata);
        t_plan_row row;
        row = '{kind: ROW_BEAT, reg_idx: '0, reg_val: '0, cmd: cmd, smp: smp, ridx: ridx,
                typed: 1'b1, want: {acc, cap, done, rdata}};
        plan.push_back(row);
    endfunction

    initial begin
        t_plan_row row;
        int sent;
        int phase_len;
        int roll;
        int lvl;
        int v;
        int run_left;
        logic hi;
        logic en;
        logic [MODE_W-1:0] mode;
        logic [SAMPLE_W-1:0] level;
        logic [OFFSET_W-1:0] off;
        logic cmd;
        logic [SAMPLE_W-1:0] smp;
        logic [RIDX_W-1:0] ridx;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_cmd = CMD_SAMPLE;
        i_sample = '0;
        i_read_index = '0;
        i_out_stall = 1'b0;
        beat_typed = 1'b0;
        beat_want = '0;
        results_seen = 0;
        fail_count = 0;
        calm = 1'b0;
        hold_left = 0;
        burst_left = 0;
        held_off = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            hist_mem[i] = '0;
            cap_mem[i] = '0;
        end
        hist_wp = '0;
        cap_wp = '0;
        triggered = 1'b0;
        cfg_trig_en = 1'b0;
        cfg_mode = MODE_RISING;
        cfg_level = '0;
        cfg_offset = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Free-running after reset: empty store, limit sample, drops.
        plan_fixed(CMD_READ, 16'h0000, 10'd0, 1'b0, 1'b0, 1'b0, 16'd0);
        plan_fixed(CMD_READ, 16'hffff, 10'd1023, 1'b0, 1'b0, 1'b0, 16'd0);
        plan_fixed(CMD_SAMPLE, 16'd4095, 10'd0, 1'b1, 1'b0, 1'b0, 16'd0);
        plan_fixed(CMD_SAMPLE, 16'd4096, 10'd1023, 1'b0, 1'b0, 1'b0, 16'd0);
        plan_fixed(CMD_SAMPLE, 16'hffff, 10'd0, 1'b0, 1'b0, 1'b0, 16'd0);
        plan_fixed(CMD_SAMPLE, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 16'd0);
        plan_fixed(CMD_READ, 16'd0, 10'd0, 1'b0, 1'b0, 1'b0, 16'd4095);
        // Rising edge with the largest pre-trigger count: the store is full
        // straight after the firing sample, so the next one rearms.
        plan_cfg(CFG_TRIG_EN, 16'd1);
        plan_cfg(CFG_TRIG_MODE, 16'(MODE_RISING));
        plan_cfg(CFG_TRIG_LEVEL, 16'd100);
        plan_cfg(CFG_PRE_OFFSET, 16'h01ff);
        plan_beat(CMD_SAMPLE, 16'd100, 10'd0);
        plan_beat(CMD_SAMPLE, 16'd101, 10'd0);
        plan_beat(CMD_SAMPLE, 16'd50, 10'd0);
        plan_beat(CMD_SAMPLE, 16'd150, 10'd0);
        plan_fixed(CMD_SAMPLE, 16'd7, 10'd0, 1'b1, 1'b0, 1'b1, 16'd0);
        plan_beat(CMD_READ, 16'd0, 10'd1022);
        plan_beat(CMD_READ, 16'd0, 10'd1023);
        // Falling edge with no pre-trigger history at all.
        plan_cfg(CFG_TRIG_MODE, 16'(MODE_FALLING));
        plan_cfg(CFG_TRIG_LEVEL, 16'd2000);
        plan_cfg(CFG_PRE_OFFSET, 16'h0200);
        plan_beat(CMD_SAMPLE, 16'd3000, 10'd0);
        plan_beat(CMD_SAMPLE, 16'd1000, 10'd0);
        plan_fixed(CMD_SAMPLE, 16'd5000, 10'd0, 1'b0, 1'b1, 1'b0, 16'd0);
        plan_beat(CMD_READ, 16'd0, 10'd0);
        // Switching triggering off abandons the capture.
        plan_cfg(CFG_TRIG_EN, 16'd0);
        plan_fixed(CMD_SAMPLE, 16'd10, 10'd0, 1'b1, 1'b0, 1'b0, 16'd0);
        // Modes that never trigger.
        plan_cfg(CFG_TRIG_EN, 16'd1);
        plan_cfg(CFG_TRIG_MODE, 16'(MODE_NEVER));
        plan_beat(CMD_SAMPLE, 16'd0, 10'd0);
        plan_beat(CMD_SAMPLE, 16'd4000, 10'd0);
        plan_cfg(CFG_TRIG_MODE, 16'(MODE_SPARE));
        plan_beat(CMD_SAMPLE, 16'd0, 10'd0);
        plan_beat(CMD_SAMPLE, 16'd4000, 10'd0);
        // A level at full scale cannot be crossed upwards.
        plan_cfg(CFG_TRIG_LEVEL, 16'hffff);
        plan_cfg(CFG_TRIG_MODE, 16'(MODE_RISING));
        plan_beat(CMD_SAMPLE, 16'd4095, 10'd0);
        plan_beat(CMD_READ, 16'd0, 10'd1023);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_beat(row.cmd, row.smp, row.ridx, row.typed, row.want);
            end
        end

        sent = 0;
        hi = 1'b0;
        run_left = 0;
        while (sent < RANDOM_BEATS) begin
            settle();
            en = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 9);
            if (roll < 4) mode = MODE_RISING;
            else if (roll < 8) mode = MODE_FALLING;
            else if (roll < 9) mode = MODE_NEVER;
            else mode = MODE_SPARE;
            roll = $urandom_range(0, 99);
            if (roll < 10) level = 16'd0;
            else if (roll < 15) level = MAX_SAMPLE;
            else if (roll < 20) level = 16'hffff;
            else level = 16'($urandom_range(1, 4094));
            // Large pre-trigger counts keep captures short; the empty-history
            // extreme takes a whole store of samples to finish.
            roll = $urandom_range(0, 99);
            if (roll < 30) off = 10'h1ff;
            else if (roll < 45) off = 10'h200;
            else off = 10'($urandom);
            // Bits above each register's width are noise and must be ignored.
            write_reg(CFG_TRIG_EN, {15'($urandom), en});
            write_reg(CFG_TRIG_MODE, {14'($urandom), mode});
            write_reg(CFG_TRIG_LEVEL, level);
            write_reg(CFG_PRE_OFFSET, {6'($urandom), off});
            lvl = int'(level);
            phase_len = $urandom_range(100, 250);
            for (int k = 0; k < phase_len && sent < RANDOM_BEATS; k++) begin
                calm = (sent >= RANDOM_BEATS - CALM_BEATS);
                roll = $urandom_range(0, 99);
                cmd = CMD_SAMPLE;
                smp = 16'($urandom);
                ridx = 10'($urandom);
                if (roll < 8) begin
                    cmd = CMD_READ;
                end else if (roll < 16) begin
                    smp = 16'($urandom_range(int'(MAX_SAMPLE) + 1, 65535));
                end else if (roll < 26 || !en) begin
                    smp = 16'($urandom_range(0, int'(MAX_SAMPLE)));
                end else begin
                    // Square wave about the level, so edges come in both senses.
                    if (run_left == 0) begin
                        hi = ~hi;
                        run_left = $urandom_range(1, 6);
                    end
                    run_left--;
                    if (hi) v = lvl + 1 + $urandom_range(0, 300);
                    else v = lvl - 1 - $urandom_range(0, 300);
                    if (v > int'(MAX_SAMPLE)) v = int'(MAX_SAMPLE);
                    if (v < 0) v = 0;
                    smp = 16'(v);
                end
                send_beat(cmd, smp, ridx, 1'b0, '0);
                sent++;
            end
        end

        settle();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("edge_triggered_sample_capture verification clean");
        end else begin
            $display("edge_triggered_sample_capture verification failed");
        end
        $finish;
    end

endmodule
